// File: rtl/bfa_pkg.sv
package bfa_pkg;

    localparam int MAX_BLOCKS    = 256;
    localparam int IDX_W         = $clog2(MAX_BLOCKS);
    localparam int CNT_W         = IDX_W + 1;
    localparam int ALIGN         = 8;
    localparam int DEFAULT_START = 512;

    localparam int REQ_W  = 24;
    localparam int SIZE_W = 25;
    localparam int CFG_W  = 21;
    localparam int FREE_W = 32;
    localparam int BLK_W  = 8;

    typedef struct packed {
        logic [BLK_W-1:0]  blk;
        logic [FREE_W-1:0] free;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SR_INIT,
        ST_SR_PROBE,
        ST_SR_CMP,
        ST_SR_FINAL,
        ST_SR_FCHK,
        ST_ALLOC_RET,
        ST_HIT_WR,
        ST_CAP,
        ST_NEW_WR,
        ST_SCAN,
        ST_SCAN_CHK,
        ST_SORT_RD_I,
        ST_SORT_RD_P,
        ST_SORT_WR,
        ST_SORT_RET,
        ST_RESTORE,
        ST_NODE,
        ST_NODE_CHK,
        ST_NODE_RET,
        ST_FMV_RD,
        ST_FMV_WR,
        ST_UNWIND,
        ST_POP_GOT,
        ST_MV_WR,
        ST_PLACE,
        ST_RESULT
    } state_t;

endpackage

// File: rtl/bfa_ram.sv
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/best_fit_block_pool_allocator_unit.sv
// Best-fit block pool allocator.
// Input channel (s_valid/s_ready, s_req_size): one allocation request per
// transfer. Result channel (m_valid/m_ready): ok, block id, offset inside the
// block (counted down from the block top), and the size of a block opened for
// the request. Config channel (cfg_valid/cfg_ready): start_block_bytes; a
// write also empties the pool. cfg_ready and s_ready are high only when the
// sequencer is idle; s_ready also drops while a config transfer is offered.
// One request is worked by a sequencer around a single table RAM port and one
// compare/subtract datapath. A request runs two binary searches over the open
// records, plus the full-block scan over skipped records, plus one search per
// step of the re-sort move chain; long skip scans or move chains make a
// request run long.
// Results sit in an output register; the next request is taken while a result
// waits, and the sequencer holds in its last state only if a second result is
// ready before the first is taken. Reset empties the pool with the default
// start size of 512 bytes; table contents need no clearing.
module best_fit_block_pool_allocator_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bfa_pkg::REQ_W-1:0]     s_req_size,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_ok,
    output logic [bfa_pkg::BLK_W-1:0]     m_block_id,
    output logic [bfa_pkg::FREE_W-1:0]    m_offset,
    output logic                          m_new_block,
    output logic [bfa_pkg::FREE_W-1:0]    m_new_block_bytes,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bfa_pkg::CFG_W-1:0]     cfg_start_block_bytes
);
    import bfa_pkg::*;

    function automatic logic [FREE_W-1:0] dbl_sat(input logic [FREE_W-1:0] v);
        dbl_sat = v[FREE_W-1] ? '1 : {v[FREE_W-2:0], 1'b0};
    endfunction

    function automatic logic [SIZE_W-1:0] align_up(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] t;
        t = v + SIZE_W'(ALIGN - 1);
        align_up = (t / SIZE_W'(ALIGN)) * SIZE_W'(ALIGN);
    endfunction

    // sequencer
    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    // pool state
    logic [CNT_W-1:0]  bc_reg, bc_next;
    logic [CNT_W-1:0]  foi_reg, foi_next;
    logic [CNT_W-1:0]  cap_reg, cap_next;
    logic [FREE_W-1:0] nbb_reg, nbb_next;
    logic [FREE_W-1:0] thr_reg, thr_next;

    // search unit
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [FREE_W:0]   need_reg, need_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic              found_reg, found_next;
    entry_t            word_reg, word_next;

    // re-sort
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  pop_reg, pop_next;
    logic [CNT_W-1:0]  sp_reg, sp_next;
    logic [FREE_W-1:0] keep_reg, keep_next;
    logic [FREE_W-1:0] prev_reg, prev_next;
    logic [BLK_W-1:0]  tb_reg, tb_next;

    // pending result
    logic              res_ok_reg, res_ok_next;
    logic [BLK_W-1:0]  res_blk_reg, res_blk_next;
    logic [FREE_W-1:0] res_off_reg, res_off_next;
    logic              res_newb_reg, res_newb_next;
    logic [FREE_W-1:0] res_nbytes_reg, res_nbytes_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic              m_ok_reg, m_ok_next;
    logic [BLK_W-1:0]  m_blk_reg, m_blk_next;
    logic [FREE_W-1:0] m_off_reg, m_off_next;
    logic              m_newb_reg, m_newb_next;
    logic [FREE_W-1:0] m_nbytes_reg, m_nbytes_next;

    // memories
    logic              tab_we;
    logic [IDX_W-1:0]  tab_addr;
    entry_t            tab_wdata;
    entry_t            tab_rdata;
    logic              stk_we;
    logic [IDX_W-1:0]  stk_addr;
    logic [IDX_W-1:0]  stk_wdata;
    logic [IDX_W-1:0]  stk_rdata;

    // helpers
    logic [CNT_W-1:0]  mid;
    logic [CNT_W-1:0]  k_p1;
    logic              probe_lt;
    logic [FREE_W-1:0] bs;
    logic [CNT_W+2:0]  foi_p1;
    logic [CNT_W+2:0]  foi_x3;
    logic [CNT_W+2:0]  old_x2;
    logic [CNT_W:0]    cap_dbl;
    logic [CNT_W-1:0]  cap_new;
    logic [FREE_W-1:0] hit_free;
    logic [SIZE_W-1:0] cfg_aligned;
    logic [FREE_W-1:0] cfg_nbb;

    bfa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_table (
        .clk   (aclk),
        .we    (tab_we),
        .addr  (tab_addr),
        .wdata (tab_wdata),
        .rdata (tab_rdata)
    );

    // indices of the pending move chain, popped in reverse
    bfa_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BLOCKS)) u_stack (
        .clk   (aclk),
        .we    (stk_we),
        .addr  (stk_addr),
        .wdata (stk_wdata),
        .rdata (stk_rdata)
    );

    // a config transfer wins over a request offered in the same cycle
    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);

    assign m_valid           = m_valid_reg;
    assign m_ok              = m_ok_reg;
    assign m_block_id        = m_blk_reg;
    assign m_offset          = m_off_reg;
    assign m_new_block       = m_newb_reg;
    assign m_new_block_bytes = m_nbytes_reg;

    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign k_p1     = k_reg + CNT_W'(1);
    assign probe_lt = ({1'b0, tab_rdata.free} < need_reg);
    assign bs       = (nbb_reg < FREE_W'(size_reg)) ? FREE_W'(size_reg) : nbb_reg;
    assign hit_free = word_reg.free - FREE_W'(size_reg);

    // first_open < (2*old)/3  <=>  3*(first_open+1) <= 2*old
    assign foi_p1  = (CNT_W+3)'(foi_reg) + (CNT_W+3)'(1);
    assign foi_x3  = foi_p1 + (foi_p1 << 1);
    assign old_x2  = (CNT_W+3)'(cap_reg) << 1;
    assign cap_dbl = (CNT_W+1)'(cap_reg) << 1;
    assign cap_new = (cap_reg == '0) ? CNT_W'(1) :
                     (cap_dbl > (CNT_W+1)'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) :
                     cap_dbl[CNT_W-1:0];

    assign cfg_aligned = align_up(SIZE_W'(cfg_start_block_bytes));
    assign cfg_nbb     = (cfg_start_block_bytes == '0) ? FREE_W'(DEFAULT_START / 2) :
                         FREE_W'(cfg_aligned >> 1);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && !cfg_valid) begin
                    state_next = ST_SR_INIT;
                end
            end
            ST_SR_INIT:  state_next = (foi_reg < bc_reg) ? ST_SR_PROBE : ST_SR_FINAL;
            ST_SR_PROBE: state_next = ST_SR_CMP;
            ST_SR_CMP: begin
                if (probe_lt) begin
                    state_next = (k_p1 < hi_reg) ? ST_SR_PROBE : ST_SR_FINAL;
                end else begin
                    state_next = (lo_reg < k_reg) ? ST_SR_PROBE : ST_SR_FINAL;
                end
            end
            ST_SR_FINAL: state_next = (k_reg < bc_reg) ? ST_SR_FCHK : ret_reg;
            ST_SR_FCHK:  state_next = ret_reg;
            ST_ALLOC_RET: begin
                priority if (found_reg) begin
                    state_next = ST_HIT_WR;
                end else if (bc_reg >= cap_reg) begin
                    state_next = (cap_reg >= CNT_W'(MAX_BLOCKS)) ? ST_RESULT : ST_CAP;
                end else begin
                    state_next = ST_NEW_WR;
                end
            end
            ST_HIT_WR:    state_next = ST_SORT_RD_I;
            ST_CAP:       state_next = ST_NEW_WR;
            ST_NEW_WR:    state_next = ST_SCAN;
            ST_SCAN:      state_next = (foi_reg < bc_reg) ? ST_SCAN_CHK : ST_SORT_RD_I;
            ST_SCAN_CHK:  state_next = (tab_rdata.free <= thr_reg) ? ST_SCAN : ST_SORT_RD_I;
            ST_SORT_RD_I: state_next = (i_reg == '0) ? ST_RESULT : ST_SORT_RD_P;
            ST_SORT_RD_P: state_next = ST_SORT_WR;
            ST_SORT_WR:   state_next = ST_SR_INIT;
            ST_SORT_RET: begin
                state_next = (found_reg && (k_reg < CNT_W'(i_reg))) ? ST_NODE : ST_RESTORE;
            end
            ST_RESTORE:   state_next = ST_RESULT;
            ST_NODE: begin
                priority if (sp_reg >= CNT_W'(MAX_BLOCKS)) begin
                    state_next = ST_UNWIND;
                end else if (CNT_W'(cur_reg) + CNT_W'(1) == CNT_W'(i_reg)) begin
                    state_next = ST_FMV_RD;
                end else begin
                    state_next = ST_NODE_CHK;
                end
            end
            ST_NODE_CHK:  state_next = (tab_rdata.free == prev_reg) ? ST_FMV_RD : ST_SR_INIT;
            ST_NODE_RET:  state_next = found_reg ? ST_NODE : ST_UNWIND;
            ST_FMV_RD:    state_next = ST_FMV_WR;
            ST_FMV_WR:    state_next = ST_UNWIND;
            ST_UNWIND:    state_next = (sp_reg == '0) ? ST_PLACE : ST_POP_GOT;
            ST_POP_GOT:   state_next = ST_MV_WR;
            ST_MV_WR:     state_next = ST_UNWIND;
            ST_PLACE:     state_next = ST_RESULT;
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and memory port
    always_comb begin
        ret_next        = ret_reg;
        bc_next         = bc_reg;
        foi_next        = foi_reg;
        cap_next        = cap_reg;
        nbb_next        = nbb_reg;
        thr_next        = thr_reg;
        size_next       = size_reg;
        need_next       = need_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        k_next          = k_reg;
        found_next      = found_reg;
        word_next       = word_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        cur_next        = cur_reg;
        pop_next        = pop_reg;
        sp_next         = sp_reg;
        keep_next       = keep_reg;
        prev_next       = prev_reg;
        tb_next         = tb_reg;
        res_ok_next     = res_ok_reg;
        res_blk_next    = res_blk_reg;
        res_off_next    = res_off_reg;
        res_newb_next   = res_newb_reg;
        res_nbytes_next = res_nbytes_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_ok_next       = m_ok_reg;
        m_blk_next      = m_blk_reg;
        m_off_next      = m_off_reg;
        m_newb_next     = m_newb_reg;
        m_nbytes_next   = m_nbytes_reg;
        tab_we          = 1'b0;
        tab_addr        = k_reg[IDX_W-1:0];
        tab_wdata       = word_reg;
        stk_we          = 1'b0;
        stk_addr        = sp_reg[IDX_W-1:0];
        stk_wdata       = cur_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_valid) begin
                    // fresh pool with the new start size
                    bc_next  = '0;
                    foi_next = '0;
                    cap_next = '0;
                    thr_next = '0;
                    nbb_next = cfg_nbb;
                end else if (s_valid) begin
                    size_next = align_up(SIZE_W'(s_req_size));
                    need_next = (FREE_W+1)'(align_up(SIZE_W'(s_req_size)));
                    ret_next  = ST_ALLOC_RET;
                end
            end
            ST_SR_INIT: begin
                lo_next = foi_reg;
                hi_next = bc_reg;
                k_next  = '0;
            end
            ST_SR_PROBE: begin
                k_next   = mid;
                tab_addr = mid[IDX_W-1:0];
            end
            ST_SR_CMP: begin
                if (probe_lt) begin
                    lo_next = k_p1;
                    k_next  = k_p1;
                end else begin
                    hi_next = k_reg;
                end
            end
            ST_SR_FINAL: begin
                tab_addr   = k_reg[IDX_W-1:0];
                found_next = 1'b0;
            end
            ST_SR_FCHK: begin
                found_next = !probe_lt;
                word_next  = tab_rdata;
            end
            ST_ALLOC_RET: begin
                i_next = k_reg[IDX_W-1:0];
                if (!found_reg && (bc_reg >= cap_reg) && (cap_reg >= CNT_W'(MAX_BLOCKS))) begin
                    // table full: all-zero result, pool untouched
                    res_ok_next     = 1'b0;
                    res_blk_next    = '0;
                    res_off_next    = '0;
                    res_newb_next   = 1'b0;
                    res_nbytes_next = '0;
                end
            end
            ST_HIT_WR: begin
                tab_we          = 1'b1;
                tab_addr        = i_reg;
                tab_wdata.blk   = word_reg.blk;
                tab_wdata.free  = hit_free;
                res_ok_next     = 1'b1;
                res_blk_next    = word_reg.blk;
                res_off_next    = hit_free;
                res_newb_next   = 1'b0;
                res_nbytes_next = '0;
            end
            ST_CAP: begin
                nbb_next = dbl_sat(nbb_reg);
                if (foi_x3 <= old_x2) begin
                    thr_next = (thr_reg == '0) ? FREE_W'(ALIGN) : dbl_sat(thr_reg);
                end
                cap_next = cap_new;
            end
            ST_NEW_WR: begin
                i_next          = bc_reg[IDX_W-1:0];
                tab_we          = 1'b1;
                tab_addr        = bc_reg[IDX_W-1:0];
                tab_wdata.blk   = BLK_W'(bc_reg[IDX_W-1:0]);
                tab_wdata.free  = bs - FREE_W'(size_reg);
                bc_next         = bc_reg + CNT_W'(1);
                res_ok_next     = 1'b1;
                res_blk_next    = BLK_W'(bc_reg[IDX_W-1:0]);
                res_off_next    = bs - FREE_W'(size_reg);
                res_newb_next   = 1'b1;
                res_nbytes_next = bs;
            end
            ST_SCAN: begin
                tab_addr = foi_reg[IDX_W-1:0];
            end
            ST_SCAN_CHK: begin
                if (tab_rdata.free <= thr_reg) begin
                    foi_next = foi_reg + CNT_W'(1);
                end
            end
            ST_SORT_RD_I: begin
                tab_addr = i_reg;
            end
            ST_SORT_RD_P: begin
                keep_next = tab_rdata.free;
                tb_next   = tab_rdata.blk;
                tab_addr  = i_reg - IDX_W'(1);
            end
            ST_SORT_WR: begin
                // record i holds its neighbor's free count during the search
                prev_next      = tab_rdata.free;
                tab_we         = 1'b1;
                tab_addr       = i_reg;
                tab_wdata.blk  = tb_reg;
                tab_wdata.free = tab_rdata.free;
                need_next      = (FREE_W+1)'(keep_reg) + (FREE_W+1)'(1);
                ret_next       = ST_SORT_RET;
            end
            ST_SORT_RET: begin
                j_next   = k_reg[IDX_W-1:0];
                cur_next = k_reg[IDX_W-1:0];
                sp_next  = '0;
            end
            ST_RESTORE: begin
                tab_we         = 1'b1;
                tab_addr       = i_reg;
                tab_wdata.blk  = tb_reg;
                tab_wdata.free = keep_reg;
            end
            ST_NODE: begin
                tab_addr = cur_reg;
            end
            ST_NODE_CHK: begin
                need_next = (FREE_W+1)'(tab_rdata.free) + (FREE_W+1)'(1);
                ret_next  = ST_NODE_RET;
            end
            ST_NODE_RET: begin
                if (found_reg) begin
                    stk_we    = 1'b1;
                    stk_addr  = sp_reg[IDX_W-1:0];
                    stk_wdata = cur_reg;
                    sp_next   = sp_reg + CNT_W'(1);
                    cur_next  = k_reg[IDX_W-1:0];
                end
            end
            ST_FMV_RD: begin
                tab_addr = cur_reg;
            end
            ST_FMV_WR: begin
                tab_we    = 1'b1;
                tab_addr  = i_reg;
                tab_wdata = tab_rdata;
            end
            ST_UNWIND: begin
                stk_addr = sp_reg[IDX_W-1:0] - IDX_W'(1);
            end
            ST_POP_GOT: begin
                pop_next = stk_rdata;
                tab_addr = stk_rdata;
            end
            ST_MV_WR: begin
                tab_we    = 1'b1;
                tab_addr  = cur_reg;
                tab_wdata = tab_rdata;
                cur_next  = pop_reg;
                sp_next   = sp_reg - CNT_W'(1);
            end
            ST_PLACE: begin
                tab_we         = 1'b1;
                tab_addr       = j_reg;
                tab_wdata.blk  = tb_reg;
                tab_wdata.free = keep_reg;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_ok_next     = res_ok_reg;
                    m_blk_next    = res_blk_reg;
                    m_off_next    = res_off_reg;
                    m_newb_next   = res_newb_reg;
                    m_nbytes_next = res_nbytes_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_ALLOC_RET;
            bc_reg      <= '0;
            foi_reg     <= '0;
            cap_reg     <= '0;
            nbb_reg     <= FREE_W'(DEFAULT_START / 2);
            thr_reg     <= '0;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            bc_reg      <= bc_next;
            foi_reg     <= foi_next;
            cap_reg     <= cap_next;
            nbb_reg     <= nbb_next;
            thr_reg     <= thr_next;
            sp_reg      <= sp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        size_reg       <= size_next;
        need_reg       <= need_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        k_reg          <= k_next;
        found_reg      <= found_next;
        word_reg       <= word_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        cur_reg        <= cur_next;
        pop_reg        <= pop_next;
        keep_reg       <= keep_next;
        prev_reg       <= prev_next;
        tb_reg         <= tb_next;
        res_ok_reg     <= res_ok_next;
        res_blk_reg    <= res_blk_next;
        res_off_reg    <= res_off_next;
        res_newb_reg   <= res_newb_next;
        res_nbytes_reg <= res_nbytes_next;
        m_ok_reg       <= m_ok_next;
        m_blk_reg      <= m_blk_next;
        m_off_reg      <= m_off_next;
        m_newb_reg     <= m_newb_next;
        m_nbytes_reg   <= m_nbytes_next;
    end

    // skip pointer never passes the block count
    a_foi_le_bc: assert property (@(posedge aclk) disable iff (!aresetn)
        foi_reg <= bc_reg)
        else $error("first open index beyond block count");

    a_bc_le_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        bc_reg <= cap_reg)
        else $error("block count beyond table capacity");

    a_cap_pow2: assert property (@(posedge aclk) disable iff (!aresetn)
        cap_reg == '0 || $onehot(cap_reg))
        else $error("table capacity not a power of two");

    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= CNT_W'(MAX_BLOCKS))
        else $error("move chain stack overflow");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ok_reg) |-> (!m_newb_reg && m_off_reg == '0 && m_nbytes_reg == '0))
        else $error("failed result carries nonzero fields");

endmodule
